[src/ued_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ued_pkg: shared types and constants for the echo distance averager
// Field widths, status and level codes, register indexes, the configuration
// record and the entry that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package ued_pkg;

	// field widths
	localparam int ECHO_W   = 15;
	localparam int DIST_W   = 18;
	localparam int STATUS_W = 3;
	localparam int LEVEL_W  = 2;
	localparam int CM_W     = 10;
	localparam int OFFS_W   = 16;
	localparam int SPR_W    = 5;
	localparam int CIDX_W   = 3;
	localparam int CDATA_W  = 16;

	// 0.0343 cm/us scaled by 65536; a half echo width times this, >> 8, is 1/256 cm
	localparam int K_W                = 12;
	localparam logic [K_W-1:0] SOUND_Q16 = 12'd2248;
	localparam int PROD_W             = ECHO_W - 1 + K_W;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_ECHO = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_NEAR    = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_FAR     = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_NONPOS  = 3'd4;

	// level codes
	localparam logic [LEVEL_W-1:0] LEVEL_OK      = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_LOW     = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_HIGH    = 2'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_UNKNOWN = 2'd3;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_SAMPLES = 3'd0;
	localparam logic [CIDX_W-1:0] REG_MIN     = 3'd1;
	localparam logic [CIDX_W-1:0] REG_MAX     = 3'd2;
	localparam logic [CIDX_W-1:0] REG_OFFSET  = 3'd3;
	localparam logic [CIDX_W-1:0] REG_NEAR    = 3'd4;
	localparam logic [CIDX_W-1:0] REG_FAR     = 3'd5;

	typedef struct packed {
		logic [SPR_W-1:0]  samples;
		logic [CM_W-1:0]   min_cm;
		logic [CM_W-1:0]   max_cm;
		logic [OFFS_W-1:0] offset_q8;
		logic [CM_W-1:0]   near_cm;
		logic [CM_W-1:0]   far_cm;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		samples:   5'd1,
		min_cm:    10'd20,
		max_cm:    10'd600,
		offset_q8: 16'd0,
		near_cm:   10'd50,
		far_cm:    10'd100
	};

	// classified sample handed to the back end
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DIST_W-1:0]   distance;
	} sample_t;

endpackage

[src/ued_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ued_front: echo capture front end
// Registers the incoming item, scales the echo width to a distance, then
// range-checks it, applies the offset and pushes a classified sample.
// ----------------------------------------------------------------------------
module ued_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ued_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         echo_seen,
	input  logic [ued_pkg::ECHO_W-1:0]   echo_us,
	output logic                         push,
	output ued_pkg::sample_t             push_data,
	input  logic                         q_full
);
	import ued_pkg::*;

	logic                seen_s1, seen_s2;
	logic [ECHO_W-1:0]   echo_s1;
	logic [DIST_W-1:0]   dist_s2;
	logic                vld_s1_q, vld_s2_q;
	logic                ld_s1, ld_s2, adv_s2;
	logic [PROD_W-1:0]   prod;
	logic [DIST_W-1:0]   min_q8, max_q8, offs;

	// stage handshakes
	assign adv_s2   = vld_s2_q && !q_full;
	assign ld_s2    = vld_s1_q && (!vld_s2_q || adv_s2);
	assign in_stall = vld_s1_q && !ld_s2;
	assign ld_s1    = in_valid && !in_stall;
	assign push     = adv_s2;

	// half echo width times speed of sound
	assign prod = PROD_W'(echo_s1[ECHO_W-1:1]) * PROD_W'(SOUND_Q16);

	// range and offset checks, in order of precedence
	always_comb begin
		min_q8 = {cfg.min_cm, 8'd0};
		max_q8 = {cfg.max_cm, 8'd0};
		offs   = DIST_W'(cfg.offset_q8);
		push_data.distance = '0;
		if (!seen_s2) begin
			push_data.status = STATUS_NO_ECHO;
		end else if (dist_s2 < min_q8) begin
			push_data.status = STATUS_NEAR;
		end else if (dist_s2 > max_q8) begin
			push_data.status = STATUS_FAR;
		end else if (offs != '0 && dist_s2 <= offs) begin
			push_data.status = STATUS_NONPOS;
		end else begin
			push_data.status   = STATUS_OK;
			push_data.distance = dist_s2 - offs;
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1_q <= 1'b0;
			vld_s2_q <= 1'b0;
		end else begin
			if (ld_s1)
				vld_s1_q <= 1'b1;
			else if (ld_s2)
				vld_s1_q <= 1'b0;
			if (ld_s2)
				vld_s2_q <= 1'b1;
			else if (adv_s2)
				vld_s2_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			seen_s1 <= echo_seen;
			echo_s1 <= echo_us;
		end
		if (ld_s2) begin
			seen_s2 <= seen_s1;
			dist_s2 <= prod[PROD_W-1:8];
		end
	end

endmodule

[src/ued_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ued_queue: two-entry sample queue
// Decouples the front end from the back end so each can stall on its own.
// ----------------------------------------------------------------------------
module ued_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ued_pkg::sample_t  push_data,
	output logic              full,
	input  logic              pop,
	output ued_pkg::sample_t  pop_data,
	output logic              not_empty
);
	import ued_pkg::*;

	localparam int DEPTH = 2;

	sample_t     mem_q [DEPTH];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;

	assign full      = (cnt_q == 2'(DEPTH));
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

[src/ued_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ued_back: batch accumulator, divider and result register
// Sums good samples, divides the batch sum by its count one quotient bit a
// cycle, classifies the level and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ued_back #(
	parameter int MAX_SAMPLES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ued_pkg::cfg_t                  cfg,
	input  logic                           q_not_empty,
	input  ued_pkg::sample_t               q_data,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ued_pkg::STATUS_W-1:0]   status,
	output logic [ued_pkg::LEVEL_W-1:0]    level,
	output logic [ued_pkg::DIST_W-1:0]     avg_distance
);
	import ued_pkg::*;

	localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W     = DIST_W + CNT_W;
	localparam int DIV_STEPS = DIST_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q, cnt_next, n_eff, div_q, rem_q;
	logic [SUM_W-1:0]    sum_q, sum_next;
	logic [DIST_W-1:0]   quo_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W:0]      trial;
	logic                trial_ge, done, out_free, is_good, load_out;
	logic [DIST_W-1:0]   near_q8, far_q8;
	logic [LEVEL_W-1:0]  lvl;
	logic                out_vld_q;
	logic [STATUS_W-1:0] status_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [DIST_W-1:0]   avg_q;

	assign out_valid    = out_vld_q;
	assign status       = status_q;
	assign level        = level_q;
	assign avg_distance = avg_q;
	assign out_free     = !out_vld_q || !out_stall;
	assign is_good      = (q_data.status == STATUS_OK);

	// batch length: zero counts as one, saturated at the maximum
	always_comb begin
		if (cfg.samples == '0)
			n_eff = CNT_W'(1);
		else if (32'(cfg.samples) > MAX_SAMPLES)
			n_eff = CNT_W'(MAX_SAMPLES);
		else
			n_eff = CNT_W'(cfg.samples);
	end

	assign cnt_next = cnt_q + CNT_W'(1);
	assign sum_next = sum_q + SUM_W'(q_data.distance);
	assign done     = (cnt_next >= n_eff);
	assign pop      = (state_q == ST_IDLE) && q_not_empty && (is_good || out_free);

	// result register loads on an error item or when a reading is emitted
	assign load_out = ((state_q == ST_IDLE) && pop && !is_good)
		|| ((state_q == ST_EMIT) && out_free);

	// restoring divide step
	assign trial    = {rem_q, quo_q[DIST_W-1]};
	assign trial_ge = (trial >= (CNT_W+1)'(div_q));

	// level class of the quotient
	always_comb begin
		near_q8 = {cfg.near_cm, 8'd0};
		far_q8  = {cfg.far_cm, 8'd0};
		if (quo_q >= near_q8 && quo_q < far_q8)
			lvl = LEVEL_OK;
		else if (quo_q >= far_q8)
			lvl = LEVEL_LOW;
		else
			lvl = LEVEL_HIGH;
	end

	// sequencer, accumulator and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			sum_q     <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			div_q     <= '0;
			step_q    <= '0;
			out_vld_q <= 1'b0;
			status_q  <= STATUS_OK;
			level_q   <= LEVEL_OK;
			avg_q     <= '0;
		end else begin
			if (load_out)
				out_vld_q <= 1'b1;
			else if (!out_stall)
				out_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (!is_good) begin
							// error: report at once, drop the batch
							cnt_q     <= '0;
							sum_q     <= '0;
							status_q  <= q_data.status;
							level_q   <= LEVEL_UNKNOWN;
							avg_q     <= '0;
						end else if (done) begin
							// batch complete: the quotient fits the distance width,
							// so the top bits seed the remainder
							cnt_q   <= '0;
							sum_q   <= '0;
							div_q   <= cnt_next;
							rem_q   <= sum_next[SUM_W-1:DIST_W];
							quo_q   <= sum_next[DIST_W-1:0];
							step_q  <= '0;
							state_q <= ST_DIV;
						end else begin
							cnt_q <= cnt_next;
							sum_q <= sum_next;
						end
					end
				end
				ST_DIV: begin
					rem_q  <= trial_ge ? CNT_W'(trial - (CNT_W+1)'(div_q)) : trial[CNT_W-1:0];
					quo_q  <= {quo_q[DIST_W-2:0], trial_ge};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1))
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						status_q  <= STATUS_OK;
						level_q   <= lvl;
						avg_q     <= quo_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[src/ultrasonic_echo_distance_averager_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_distance_averager_top: echo width to averaged distance
// Input channel (in_valid/in_stall): one echo capture per item, echo_seen and
// echo_us. Output channel (out_valid/out_stall): status, level, avg_distance.
// Configuration: cfg_we/cfg_index/cfg_data, written only while idle by the
// user; the block itself does not enforce this.
// Path: an error item passes the front end stage registers, the queue and the
// result register; the item completing a batch also passes the divider.
// Throughput: the front end takes an item every cycle until the two-entry
// queue fills; the back end retires an error or a non-final good sample as it
// pops it, and a final sample only after the one bit per cycle divider.
// Reset: configuration returns to its defaults, the batch sum and count are
// cleared, no result is pending.
// Stall: a stalled result stays in the output register; the back end keeps
// accumulating until it needs that register, then the queue and front end
// fill and in_stall rises.
// ----------------------------------------------------------------------------
module ultrasonic_echo_distance_averager_top #(
	parameter int MAX_SAMPLES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ued_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [ued_pkg::CDATA_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           echo_seen,
	input  logic [ued_pkg::ECHO_W-1:0]     echo_us,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ued_pkg::STATUS_W-1:0]   status,
	output logic [ued_pkg::LEVEL_W-1:0]    level,
	output logic [ued_pkg::DIST_W-1:0]     avg_distance
);
	import ued_pkg::*;

	cfg_t    cfg_q;
	logic    push, q_full, pop, q_not_empty;
	sample_t push_data, pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLES: cfg_q.samples   <= cfg_data[SPR_W-1:0];
				REG_MIN:     cfg_q.min_cm    <= cfg_data[CM_W-1:0];
				REG_MAX:     cfg_q.max_cm    <= cfg_data[CM_W-1:0];
				REG_OFFSET:  cfg_q.offset_q8 <= cfg_data[OFFS_W-1:0];
				REG_NEAR:    cfg_q.near_cm   <= cfg_data[CM_W-1:0];
				REG_FAR:     cfg_q.far_cm    <= cfg_data[CM_W-1:0];
				default:     cfg_q           <= cfg_q;
			endcase
		end
	end

	ued_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.echo_seen (echo_seen),
		.echo_us   (echo_us),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	ued_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty)
	);

	ued_back #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_not_empty  (q_not_empty),
		.q_data       (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.level        (level),
		.avg_distance (avg_distance)
	);

endmodule

[src/ued_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ued_checker: port-level checks for the echo distance averager
// Watches the result channel: held results, error encoding, status range.
// ----------------------------------------------------------------------------
module ued_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [ued_pkg::STATUS_W-1:0]   status,
	input  logic [ued_pkg::LEVEL_W-1:0]    level,
	input  logic [ued_pkg::DIST_W-1:0]     avg_distance
);
	import ued_pkg::*;

	// a stalled result is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(level)
			&& $stable(avg_distance))
		else $error("stalled result changed");

	// an error carries unknown level and zero distance
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> level == LEVEL_UNKNOWN && avg_distance == '0)
		else $error("error result badly encoded");

	// a good reading always has a known level
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_OK |-> level != LEVEL_UNKNOWN)
		else $error("good reading with unknown level");

	// only defined status codes leave the block
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STATUS_OK || status == STATUS_NO_ECHO
			|| status == STATUS_NEAR || status == STATUS_FAR || status == STATUS_NONPOS)
		else $error("undefined status code");

endmodule

bind ultrasonic_echo_distance_averager_top ued_checker u_ued_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.level        (level),
	.avg_distance (avg_distance)
);
